@@ rtl/core/fcc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcc_pkg: shared types and constants of the file content classifier
// Byte codes, line phase encoding, register indexes and the flag bundle that
// travels from the byte tracker to the decision stage.
// ----------------------------------------------------------------------------
package fcc_pkg;

	// Byte codes
	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_LF     = 8'h0a;
	localparam logic [7:0] CH_CR     = 8'h0d;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_TILDE  = 8'h7e;
	localparam logic [7:0] CH_HASH   = 8'h23;
	localparam logic [7:0] CH_EQUALS = 8'h3d;

	// Boot signature
	localparam int          SIG_LOW_POS   = 510;
	localparam int          SIG_HIGH_POS  = 511;
	localparam logic [7:0]  SIG_LOW_BYTE  = 8'h55;
	localparam logic [7:0]  SIG_HIGH_BYTE = 8'haa;
	localparam int          BOOT_MIN_LEN  = 512;

	// Percent arithmetic
	localparam int          PCT_BITS = 7;
	localparam logic [6:0]  PCT_FULL = 7'd100;
	localparam logic [6:0]  TEXT_PCT_RESET   = 7'd90;
	localparam logic [6:0]  CONFIG_PCT_RESET = 7'd95;

	// Register indexes
	localparam int          REG_IDX_BITS   = 1;
	localparam logic [0:0]  REG_TEXT_PCT   = 1'b0;
	localparam logic [0:0]  REG_CONFIG_PCT = 1'b1;

	// Equals counter saturates here
	localparam logic [1:0]  EQ_MAX = 2'd2;
	localparam logic [1:0]  EQ_ONE = 2'd1;

	typedef enum logic [1:0] {
		PH_START   = 2'd0,
		PH_COMMENT = 2'd1,
		PH_ASSIGN  = 2'd2
	} phase_t;

	typedef struct packed {
		logic sig_low;
		logic sig_high;
	} sig_flags_t;

	localparam int FLAG_BITS = $bits(sig_flags_t);

endpackage

@@ rtl/core/fcc_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcc_if: stream channels of the file content classifier
// One channel carries file bytes in, the other carries class flag words out.
// ----------------------------------------------------------------------------
interface fcc_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last_byte;

	modport source (output valid, output data_byte, output last_byte, input ready);
	modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface fcc_class_if;
	logic valid;
	logic ready;
	logic is_text;
	logic is_config;
	logic is_binary;
	logic is_boot;

	modport source (output valid, output is_text, output is_config, output is_binary,
		output is_boot, input ready);
	modport sink (input valid, input is_text, input is_config, input is_binary,
		input is_boot, output ready);
endinterface

@@ rtl/core/fcc_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcc_front: byte tracker
// Counts bytes, text bytes, lines and good lines, and latches the boot
// signature bytes. On the last byte it pushes the file summary to the queue
// and clears for the next file.
// ----------------------------------------------------------------------------
module fcc_front #(
	parameter int COUNT_BITS = 24
) (
	input  logic                     clk,
	input  logic                     arst_n,
	fcc_byte_if.sink                 file_bytes,
	output logic                     push,
	input  logic                     push_ready,
	output logic [COUNT_BITS-1:0]    byte_total,
	output logic [COUNT_BITS-1:0]    text_total,
	output logic [COUNT_BITS-1:0]    line_total,
	output logic [COUNT_BITS-1:0]    good_total,
	output fcc_pkg::sig_flags_t      flags
);

	localparam logic [COUNT_BITS-1:0] CNT_MAX  = '1;
	localparam logic [COUNT_BITS-1:0] CNT_ONE  = COUNT_BITS'(1);
	localparam logic [COUNT_BITS-1:0] POS_LOW  = COUNT_BITS'(fcc_pkg::SIG_LOW_POS);
	localparam logic [COUNT_BITS-1:0] POS_HIGH = COUNT_BITS'(fcc_pkg::SIG_HIGH_POS);

	logic [COUNT_BITS-1:0] byte_q, text_q, line_q, good_q;
	logic [COUNT_BITS-1:0] byte_n, text_n, line_n, good_n;
	fcc_pkg::phase_t       phase_q, phase_n;
	logic [1:0]            eq_q, eq_n;
	fcc_pkg::sig_flags_t   sig_q, sig_n;
	logic [7:0]            b;
	logic                  is_txt, ends, line_inc, good_inc, accept;

	assign b = file_bytes.data_byte;
	assign file_bytes.ready = push_ready;
	assign accept = file_bytes.valid && push_ready;
	assign push = accept && file_bytes.last_byte;

	// Classify the byte
	assign is_txt = (b == fcc_pkg::CH_LF) || (b == fcc_pkg::CH_CR) || (b == fcc_pkg::CH_TAB)
		|| ((b >= fcc_pkg::CH_SPACE) && (b <= fcc_pkg::CH_TILDE));
	assign ends = (b == fcc_pkg::CH_LF) || (b == fcc_pkg::CH_NUL);

	// Track line structure
	always_comb begin
		line_inc = 1'b0;
		good_inc = 1'b0;
		phase_n  = phase_q;
		eq_n     = eq_q;
		unique case (phase_q)
			fcc_pkg::PH_COMMENT: begin
				if (ends) phase_n = fcc_pkg::PH_START;
			end
			fcc_pkg::PH_ASSIGN: begin
				if ((b == fcc_pkg::CH_EQUALS) && (eq_q != fcc_pkg::EQ_MAX)) eq_n = eq_q + 2'd1;
				if (ends) begin
					good_inc = (eq_q == fcc_pkg::EQ_ONE);
					phase_n  = fcc_pkg::PH_START;
				end
			end
			default: begin
				line_inc = 1'b1;
				phase_n  = fcc_pkg::PH_START;
				if (b == fcc_pkg::CH_LF) begin
					good_inc = 1'b1;
				end else if (b == fcc_pkg::CH_HASH) begin
					good_inc = 1'b1;
					phase_n  = fcc_pkg::PH_COMMENT;
				end else if (b != fcc_pkg::CH_NUL) begin
					eq_n    = (b == fcc_pkg::CH_EQUALS) ? fcc_pkg::EQ_ONE : 2'd0;
					phase_n = fcc_pkg::PH_ASSIGN;
				end
			end
		endcase
	end

	// Saturating counts and signature latches
	always_comb begin
		byte_n = (byte_q == CNT_MAX) ? byte_q : byte_q + CNT_ONE;
		text_n = (is_txt && (text_q != CNT_MAX)) ? text_q + CNT_ONE : text_q;
		line_n = (line_inc && (line_q != CNT_MAX)) ? line_q + CNT_ONE : line_q;
		good_n = (good_inc && (good_q != CNT_MAX)) ? good_q + CNT_ONE : good_q;
		sig_n  = sig_q;
		if (byte_q == POS_LOW) sig_n.sig_low = (b == fcc_pkg::SIG_LOW_BYTE);
		if (byte_q == POS_HIGH) sig_n.sig_high = (b == fcc_pkg::SIG_HIGH_BYTE);
	end

	// Advance on each word, clear after the last byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_q  <= '0;
			text_q  <= '0;
			line_q  <= '0;
			good_q  <= '0;
			phase_q <= fcc_pkg::PH_START;
			eq_q    <= 2'd0;
			sig_q   <= '0;
		end else if (accept) begin
			if (file_bytes.last_byte) begin
				byte_q  <= '0;
				text_q  <= '0;
				line_q  <= '0;
				good_q  <= '0;
				phase_q <= fcc_pkg::PH_START;
				eq_q    <= 2'd0;
				sig_q   <= '0;
			end else begin
				byte_q  <= byte_n;
				text_q  <= text_n;
				line_q  <= line_n;
				good_q  <= good_n;
				phase_q <= phase_n;
				eq_q    <= eq_n;
				sig_q   <= sig_n;
			end
		end
	end

	// Summary of the file, valid with push
	assign byte_total = byte_n;
	assign text_total = text_n;
	assign line_total = line_n;
	assign good_total = good_n;
	assign flags      = sig_n;

endmodule

@@ rtl/core/fcc_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcc_queue: two-entry summary queue
// Decouples the byte tracker from the decision stage so either can stall.
// ----------------------------------------------------------------------------
module fcc_queue #(
	parameter int WIDTH = 98
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_valid,
	output logic             wr_ready,
	input  logic [WIDTH-1:0] wr_data,
	output logic             rd_valid,
	input  logic             rd_ready,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [2];
	logic             wr_ptr_q, rd_ptr_q;
	logic [1:0]       count_q;
	logic             do_wr, do_rd;

	assign wr_ready = (count_q != 2'd2);
	assign rd_valid = (count_q != 2'd0);
	assign do_wr    = wr_valid && wr_ready;
	assign do_rd    = rd_valid && rd_ready;
	assign rd_data  = mem_q[rd_ptr_q];

	// Hold entries
	always_ff @(posedge clk) begin
		if (do_wr) mem_q[wr_ptr_q] <= wr_data;
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_wr) wr_ptr_q <= ~wr_ptr_q;
			if (do_rd) rd_ptr_q <= ~rd_ptr_q;
			if (do_wr && !do_rd) count_q <= count_q + 2'd1;
			else if (do_rd && !do_wr) count_q <= count_q - 2'd1;
		end
	end

endmodule

@@ rtl/core/fcc_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcc_back: class decision
// Stage 1 forms the four percent products, stage 2 compares them and holds
// the class word until it is taken.
// ----------------------------------------------------------------------------
module fcc_back #(
	parameter int COUNT_BITS = 24
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  sum_valid,
	output logic                  sum_ready,
	input  logic [COUNT_BITS-1:0] byte_total,
	input  logic [COUNT_BITS-1:0] text_total,
	input  logic [COUNT_BITS-1:0] line_total,
	input  logic [COUNT_BITS-1:0] good_total,
	input  fcc_pkg::sig_flags_t   flags,
	input  logic [6:0]            text_pct,
	input  logic [6:0]            config_pct,
	fcc_class_if.source           classes
);

	localparam int PW = COUNT_BITS + fcc_pkg::PCT_BITS;
	localparam logic [COUNT_BITS-1:0] BOOT_LEN = COUNT_BITS'(fcc_pkg::BOOT_MIN_LEN);

	logic [PW-1:0] tp_s1, tq_s1, gp_s1, gq_s1;
	logic          sig_s1, v_s1, adv_s1;
	logic          v_s2, text_s2, config_s2, boot_s2;
	logic          text_ok, config_ok;

	assign adv_s1    = v_s1 && (!v_s2 || classes.ready);
	assign sum_ready = !v_s1 || adv_s1;

	// Stage 1: products
	always_ff @(posedge clk) begin
		if (sum_valid && sum_ready) begin
			tp_s1  <= PW'(text_total) * PW'(fcc_pkg::PCT_FULL);
			tq_s1  <= PW'(byte_total) * PW'(text_pct);
			gp_s1  <= PW'(good_total) * PW'(fcc_pkg::PCT_FULL);
			gq_s1  <= PW'(line_total) * PW'(config_pct);
			sig_s1 <= flags.sig_low && flags.sig_high && (byte_total >= BOOT_LEN);
		end
	end

	// Stage 2: compares
	assign text_ok   = (tp_s1 >= tq_s1);
	assign config_ok = text_ok && (gp_s1 >= gq_s1);

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			text_s2   <= text_ok;
			config_s2 <= config_ok;
			boot_s2   <= !text_ok && sig_s1;
		end
	end

	// Valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (sum_ready) v_s1 <= sum_valid;
			if (!v_s2 || classes.ready) v_s2 <= v_s1;
		end
	end

	assign classes.valid     = v_s2;
	assign classes.is_text   = text_s2;
	assign classes.is_config = config_s2;
	assign classes.is_binary = !text_s2;
	assign classes.is_boot   = boot_s2;

endmodule

@@ rtl/core/file_content_classifier.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// file_content_classifier: text / config / binary / boot classifier
// Takes a file one byte per word and returns one class word per file.
//
//   channel     dir  payload                                  handshake
//   file_bytes  in   data_byte[7:0], last_byte                valid/ready
//   classes     out  is_text, is_config, is_binary, is_boot   valid/ready
//   cfg         in   cfg_idx[0:0], cfg_data[6:0]               cfg_we
//
// One byte is taken every cycle while the summary queue has room; the tracker
// counters update in one step. The class word passes the queue write, the
// product stage and the compare stage in turn and holds until taken. Reset
// clears counters, queue and pipeline valids and loads thresholds 90 and 95.
// Byte input stalls only while four class words wait (queue full, both
// decision stages held by the output).
// ----------------------------------------------------------------------------
module file_content_classifier #(
	parameter int COUNT_BITS = 24
) (
	input  logic                             clk,
	input  logic                             arst_n,
	fcc_byte_if.sink                         file_bytes,
	fcc_class_if.source                      classes,
	input  logic                             cfg_we,
	input  logic [fcc_pkg::REG_IDX_BITS-1:0] cfg_idx,
	input  logic [fcc_pkg::PCT_BITS-1:0]     cfg_data
);

	localparam int SW = 4 * COUNT_BITS + fcc_pkg::FLAG_BITS;

	logic [6:0]            text_pct_q, config_pct_q;
	logic                  push, push_ready, pop_valid, pop_ready;
	logic [COUNT_BITS-1:0] f_byte, f_text, f_line, f_good;
	logic [COUNT_BITS-1:0] b_byte, b_text, b_line, b_good;
	fcc_pkg::sig_flags_t   f_flags, b_flags;
	logic [SW-1:0]         wr_word, rd_word;

	// Threshold registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			text_pct_q   <= fcc_pkg::TEXT_PCT_RESET;
			config_pct_q <= fcc_pkg::CONFIG_PCT_RESET;
		end else if (cfg_we) begin
			case (cfg_idx)
				fcc_pkg::REG_TEXT_PCT:   text_pct_q <= cfg_data;
				fcc_pkg::REG_CONFIG_PCT: config_pct_q <= cfg_data;
				default: ;
			endcase
		end
	end

	fcc_front #(.COUNT_BITS(COUNT_BITS)) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.file_bytes (file_bytes),
		.push       (push),
		.push_ready (push_ready),
		.byte_total (f_byte),
		.text_total (f_text),
		.line_total (f_line),
		.good_total (f_good),
		.flags      (f_flags)
	);

	assign wr_word = {f_byte, f_text, f_line, f_good, f_flags};

	fcc_queue #(.WIDTH(SW)) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (push),
		.wr_ready (push_ready),
		.wr_data  (wr_word),
		.rd_valid (pop_valid),
		.rd_ready (pop_ready),
		.rd_data  (rd_word)
	);

	assign {b_byte, b_text, b_line, b_good, b_flags} = rd_word;

	fcc_back #(.COUNT_BITS(COUNT_BITS)) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.sum_valid  (pop_valid),
		.sum_ready  (pop_ready),
		.byte_total (b_byte),
		.text_total (b_text),
		.line_total (b_line),
		.good_total (b_good),
		.flags      (b_flags),
		.text_pct   (text_pct_q),
		.config_pct (config_pct_q),
		.classes    (classes)
	);

endmodule

@@ verif/file_content_classifier_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// file_content_classifier_tb: self-checking bench of the file classifier
// Streams files byte by byte through the byte channel and checks every class
// word against an in-bench predictor of the counters and the line tracker.
// A short table of hand-picked files comes first, then random files (config
// style lines, text, binary, mixed, and long files with a boot signature)
// under several threshold settings, with bursty input and a stalling output.
// The counters are built narrow so that a long file reaches saturation.
// ----------------------------------------------------------------------------
module file_content_classifier_tb;
	import fcc_pkg::*;

	localparam int CNT_W       = 10;
	localparam int HOLD_CYCLES = 300;
	localparam int PHASE_ITEMS = 40;

	localparam logic [CNT_W-1:0] CNT_MAX = '1;

	typedef struct packed {
		logic is_text;
		logic is_config;
		logic is_binary;
		logic is_boot;
	} class_word_t;

	typedef struct packed {
		logic [7:0]  data;
		logic        is_last;
		logic        known;
		class_word_t word;
	} dir_row_t;

	typedef enum int {FK_CONFIG, FK_TEXT, FK_BINARY, FK_MIXED, FK_LONG} file_kind_t;

	localparam class_word_t W_NONE   = '{1'b0, 1'b0, 1'b0, 1'b0};
	localparam class_word_t W_TEXT   = '{1'b1, 1'b0, 1'b0, 1'b0};
	localparam class_word_t W_CONFIG = '{1'b1, 1'b1, 1'b0, 1'b0};
	localparam class_word_t W_BINARY = '{1'b0, 1'b0, 1'b1, 1'b0};

	localparam int DIR_ROWS = 24;

	// Hand-picked files at reset thresholds; known words only where obvious
	localparam dir_row_t DIRECTED [DIR_ROWS] = '{
		// single printable byte: text, open assignment line is not good
		'{8'h41, 1'b1, 1'b1, W_TEXT},
		// lowest and highest byte alone: binary
		'{8'h00, 1'b1, 1'b1, W_BINARY},
		'{8'hff, 1'b1, 1'b1, W_BINARY},
		// blank line, then a comment that never terminates
		'{8'h0a, 1'b1, 1'b1, W_CONFIG},
		'{8'h23, 1'b1, 1'b1, W_CONFIG},
		// one assignment line ended by LF
		'{8'h6b, 1'b0, 1'b0, W_NONE},
		'{8'h3d, 1'b0, 1'b0, W_NONE},
		'{8'h31, 1'b0, 1'b0, W_NONE},
		'{8'h0a, 1'b1, 1'b0, W_NONE},
		// two equals ended by NUL, then a NUL line of its own
		'{8'h3d, 1'b0, 1'b0, W_NONE},
		'{8'h3d, 1'b0, 1'b0, W_NONE},
		'{8'h00, 1'b0, 1'b0, W_NONE},
		'{8'h00, 1'b1, 1'b0, W_NONE},
		// edges of the text range
		'{8'h09, 1'b0, 1'b0, W_NONE},
		'{8'h0d, 1'b0, 1'b0, W_NONE},
		'{8'h20, 1'b0, 1'b0, W_NONE},
		'{8'h7e, 1'b0, 1'b0, W_NONE},
		'{8'h1f, 1'b0, 1'b0, W_NONE},
		'{8'h7f, 1'b0, 1'b0, W_NONE},
		'{8'h0a, 1'b1, 1'b0, W_NONE},
		// comment closed by NUL, then an assignment left open at the end
		'{8'h23, 1'b0, 1'b0, W_NONE},
		'{8'h78, 1'b0, 1'b0, W_NONE},
		'{8'h00, 1'b0, 1'b0, W_NONE},
		'{8'h3d, 1'b1, 1'b0, W_NONE}
	};

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [REG_IDX_BITS-1:0] cfg_idx;
	logic [PCT_BITS-1:0] cfg_data;

	fcc_byte_if  byte_ch ();
	fcc_class_if class_ch ();

	file_content_classifier #(
		.COUNT_BITS(CNT_W)
	) u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.file_bytes (byte_ch),
		.classes    (class_ch),
		.cfg_we     (cfg_we),
		.cfg_idx    (cfg_idx),
		.cfg_data   (cfg_data)
	);

	// Predictor state
	logic [PCT_BITS-1:0] text_floor;
	logic [PCT_BITS-1:0] config_floor;
	logic [CNT_W-1:0]    seen_bytes;
	logic [CNT_W-1:0]    text_bytes;
	logic [CNT_W-1:0]    line_count;
	logic [CNT_W-1:0]    good_lines;
	phase_t              line_state;
	logic [1:0]          eq_count;
	logic                sig_lo_ok;
	logic                sig_hi_ok;

	class_word_t class_words_due [$];
	logic [7:0]  file_image [$];

	int mismatches;
	int burst_left;
	bit hold_req;

	// Clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Run limit
	initial begin
		#5_000_000;
		$display("FAILURE");
		$finish;
	end

	function automatic logic [CNT_W-1:0] bump(input logic [CNT_W-1:0] v);
		return (v == CNT_MAX) ? v : v + 1'b1;
	endfunction

	function automatic bit is_text_code(input logic [7:0] b);
		return b == CH_LF || b == CH_CR || b == CH_TAB || (b >= CH_SPACE && b <= CH_TILDE);
	endfunction

	function automatic logic [7:0] pick_text_byte();
		int r;
		r = $urandom_range(0, 19);
		if (r == 0) begin
			return CH_TAB;
		end else if (r == 1) begin
			return CH_CR;
		end else if (r == 2) begin
			return CH_LF;
		end
		return 8'($urandom_range(CH_SPACE, CH_TILDE));
	endfunction

	function automatic logic [7:0] pick_nontext_byte();
		logic [7:0] b;
		b = 8'($urandom_range(0, 255));
		while (is_text_code(b)) b = 8'($urandom_range(0, 255));
		return b;
	endfunction

	task automatic clear_file_counts();
		seen_bytes = '0;
		text_bytes = '0;
		line_count = '0;
		good_lines = '0;
		line_state = PH_START;
		eq_count   = 2'd0;
		sig_lo_ok  = 1'b0;
		sig_hi_ok  = 1'b0;
	endtask

	// Advance the predictor by one byte; give the class word on the last one
	task automatic classify_byte(input logic [7:0] b, input logic is_last,
			output bit produced, output class_word_t w);
		bit ends;
		bit text_ok;
		bit cfg_ok;
		ends = (b == CH_LF) || (b == CH_NUL);
		if (int'(seen_bytes) == SIG_LOW_POS) sig_lo_ok = (b == SIG_LOW_BYTE);
		if (int'(seen_bytes) == SIG_HIGH_POS) sig_hi_ok = (b == SIG_HIGH_BYTE);
		seen_bytes = bump(seen_bytes);
		if (is_text_code(b)) text_bytes = bump(text_bytes);

		// Track line structure
		case (line_state)
			PH_COMMENT: begin
				if (ends) line_state = PH_START;
			end
			PH_ASSIGN: begin
				if (b == CH_EQUALS && eq_count < EQ_MAX) eq_count = eq_count + 2'd1;
				if (ends) begin
					if (eq_count == EQ_ONE) good_lines = bump(good_lines);
					line_state = PH_START;
				end
			end
			default: begin
				line_count = bump(line_count);
				line_state = PH_START;
				if (b == CH_LF) begin
					good_lines = bump(good_lines);
				end else if (b == CH_HASH) begin
					good_lines = bump(good_lines);
					line_state = PH_COMMENT;
				end else if (b != CH_NUL) begin
					eq_count = (b == CH_EQUALS) ? EQ_ONE : 2'd0;
					line_state = PH_ASSIGN;
				end
			end
		endcase

		produced = 1'b0;
		w = W_NONE;
		if (is_last) begin
			text_ok = 64'(text_bytes) * 64'(PCT_FULL) >= 64'(text_floor) * 64'(seen_bytes);
			cfg_ok = text_ok &&
				(64'(good_lines) * 64'(PCT_FULL) >= 64'(config_floor) * 64'(line_count));
			w.is_text   = text_ok;
			w.is_config = cfg_ok;
			w.is_binary = !text_ok;
			w.is_boot   = !text_ok && int'(seen_bytes) >= BOOT_MIN_LEN && sig_lo_ok && sig_hi_ok;
			produced = 1'b1;
			clear_file_counts();
		end
	endtask

	// Offer one word, with a random gap at the start of each burst
	task automatic send_byte(input logic [7:0] b, input logic is_last, input bit known,
			input class_word_t typed_word);
		bit produced;
		class_word_t w;
		if (burst_left == 0) begin
			byte_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 200) :
				$urandom_range(1, 24);
		end
		byte_ch.valid     <= 1'b1;
		byte_ch.data_byte <= b;
		byte_ch.last_byte <= is_last;
		do @(posedge clk); while (!byte_ch.ready);
		burst_left--;
		classify_byte(b, is_last, produced, w);
		if (produced) class_words_due.push_back(known ? typed_word : w);
	endtask

	task automatic send_file();
		for (int i = 0; i < file_image.size(); i++) begin
			send_byte(file_image[i], i == file_image.size() - 1, 1'b0, W_NONE);
		end
	endtask

	// Drop valid and wait for every pending class word
	task automatic drain_results();
		byte_ch.valid <= 1'b0;
		burst_left = 0;
		while (class_words_due.size() != 0) @(posedge clk);
	endtask

	task automatic write_thresholds(input logic [PCT_BITS-1:0] t, input logic [PCT_BITS-1:0] c);
		drain_results();
		repeat (6) @(posedge clk);
		cfg_we   <= 1'b1;
		cfg_idx  <= REG_TEXT_PCT;
		cfg_data <= t;
		@(posedge clk);
		cfg_idx  <= REG_CONFIG_PCT;
		cfg_data <= c;
		@(posedge clk);
		cfg_we <= 1'b0;
		text_floor   = t;
		config_floor = c;
	endtask

	// Fill file_image with one file of the given kind
	task automatic build_file(input file_kind_t kind, input int len);
		int n_lines;
		int r;
		int eqs;
		int p;
		file_image.delete();
		case (kind)
			FK_CONFIG: begin
				n_lines = $urandom_range(1, 6);
				repeat (n_lines) begin
					r = $urandom_range(0, 15);
					if (r <= 2) begin
						file_image.push_back(CH_LF);
					end else if (r <= 5) begin
						file_image.push_back(CH_HASH);
						repeat ($urandom_range(0, 6))
							file_image.push_back(8'($urandom_range(CH_SPACE, CH_TILDE)));
						file_image.push_back(($urandom_range(0, 3) == 0) ? CH_NUL : CH_LF);
					end else if (r <= 13) begin
						repeat ($urandom_range(0, 4))
							file_image.push_back(8'(8'h61 + $urandom_range(0, 25)));
						p = $urandom_range(0, 9);
						eqs = (p == 0) ? 0 : (p == 1) ? 2 : (p == 2) ? 3 : 1;
						repeat (eqs) begin
							file_image.push_back(CH_EQUALS);
							repeat ($urandom_range(0, 3))
								file_image.push_back(8'($urandom_range(CH_SPACE, CH_TILDE)));
						end
						file_image.push_back(($urandom_range(0, 3) == 0) ? CH_NUL : CH_LF);
					end else if (r == 14) begin
						file_image.push_back(CH_NUL);
					end else begin
						file_image.push_back(CH_TAB);
						file_image.push_back(8'h76);
						file_image.push_back(CH_CR);
						file_image.push_back(CH_LF);
					end
				end
				// Leave a line open at the end now and then
				r = $urandom_range(0, 3);
				if (r == 0) begin
					file_image.push_back(8'h6b);
					file_image.push_back(CH_EQUALS);
					file_image.push_back(8'h76);
				end else if (r == 1) begin
					file_image.push_back(CH_HASH);
					file_image.push_back(8'h78);
				end
				if ($urandom_range(0, 7) == 0)
					file_image.insert($urandom_range(0, file_image.size() - 1),
						pick_nontext_byte());
			end
			FK_TEXT: begin
				repeat (len) file_image.push_back(($urandom_range(0, 15) == 0) ?
					pick_nontext_byte() : pick_text_byte());
			end
			FK_MIXED: begin
				p = $urandom_range(0, 100);
				repeat (len) file_image.push_back(($urandom_range(0, 99) < p) ?
					pick_text_byte() : pick_nontext_byte());
			end
			default: begin
				repeat (len) file_image.push_back(8'($urandom_range(0, 255)));
				if (kind == FK_LONG && len >= BOOT_MIN_LEN && $urandom_range(0, 3) != 0) begin
					file_image[SIG_LOW_POS]  = SIG_LOW_BYTE;
					file_image[SIG_HIGH_POS] = SIG_HIGH_BYTE;
				end
			end
		endcase
	endtask

	// Random files for one threshold setting after an optional long file; full drain half way
	task automatic run_random(input int budget, input int long_len);
		int sent;
		int r;
		bit paused;
		file_kind_t kind;
		sent = 0;
		paused = 1'b0;
		if (long_len > 0) begin
			build_file(FK_LONG, long_len);
			send_file();
		end
		while (sent < budget) begin
			r = $urandom_range(0, 19);
			kind = (r < 10) ? FK_CONFIG : (r < 14) ? FK_TEXT : (r < 17) ? FK_MIXED : FK_BINARY;
			build_file(kind, $urandom_range(1, 24));
			send_file();
			sent += file_image.size();
			if (!paused && sent >= budget / 2) begin
				drain_results();
				paused = 1'b1;
			end
		end
	endtask

	// Receiver: stall pattern that changes at random, and a hold of ready low on request
	initial begin
		int mode;
		int span;
		int cyc;
		mode = 0;
		span = 0;
		cyc  = 0;
		class_ch.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_req) begin
				class_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
			end
			if (span == 0) begin
				mode = $urandom_range(0, 3);
				span = $urandom_range(20, 120);
			end
			span--;
			cyc++;
			case (mode)
				0: class_ch.ready <= 1'b1;
				1: class_ch.ready <= 1'($urandom_range(0, 1));
				2: class_ch.ready <= ($urandom_range(0, 3) == 0);
				default: class_ch.ready <= (cyc % 5) != 2;
			endcase
		end
	end

	// Check each class word against the oldest prediction
	always @(posedge clk) begin
		class_word_t got;
		class_word_t want;
		if (arst_n && class_ch.valid && class_ch.ready) begin
			got = '{class_ch.is_text, class_ch.is_config, class_ch.is_binary, class_ch.is_boot};
			if (class_words_due.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected class word t=%b c=%b b=%b boot=%b", got.is_text,
						got.is_config, got.is_binary, got.is_boot);
			end else begin
				want = class_words_due.pop_front();
				if (got.is_text !== want.is_text || got.is_config !== want.is_config ||
						got.is_binary !== want.is_binary || got.is_boot !== want.is_boot) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: exp tcbx=%b%b%b%b, got tcbx=%b%b%b%b",
							want.is_text, want.is_config, want.is_binary, want.is_boot,
							got.is_text, got.is_config, got.is_binary, got.is_boot);
				end
			end
		end
	end

	// Stimulus
	initial begin
		mismatches = 0;
		burst_left = 0;
		hold_req   = 1'b0;
		text_floor   = TEXT_PCT_RESET;
		config_floor = CONFIG_PCT_RESET;
		clear_file_counts();
		arst_n <= 1'b0;
		byte_ch.valid     <= 1'b0;
		byte_ch.data_byte <= 8'h00;
		byte_ch.last_byte <= 1'b0;
		cfg_we   <= 1'b0;
		cfg_idx  <= REG_TEXT_PCT;
		cfg_data <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < DIR_ROWS; i++) begin
			send_byte(DIRECTED[i].data, DIRECTED[i].is_last, DIRECTED[i].known, DIRECTED[i].word);
		end

		// Everything is text; hold the output off while one-byte files pile up
		write_thresholds(7'd0, 7'd0);
		hold_req = 1'b1;
		repeat (8) begin
			build_file(FK_TEXT, 1);
			send_file();
		end
		run_random(PHASE_ITEMS, 0);

		write_thresholds(PCT_FULL, PCT_FULL);
		run_random(PHASE_ITEMS, 0);

		// Nothing is text above 100; a boot sized file lands here
		write_thresholds(7'd127, 7'd127);
		run_random(PHASE_ITEMS, $urandom_range(BOOT_MIN_LEN, BOOT_MIN_LEN + 4));

		write_thresholds(7'd50, 7'd75);
		run_random(PHASE_ITEMS, 0);

		write_thresholds(7'($urandom_range(0, 100)), 7'($urandom_range(0, 100)));
		run_random(PHASE_ITEMS, 0);

		// Long file that drives the counters into saturation
		write_thresholds(PCT_FULL, 7'd0);
		run_random(PHASE_ITEMS, $urandom_range(int'(CNT_MAX) + 1, int'(CNT_MAX) + 7));

		write_thresholds(7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)));
		run_random(PHASE_ITEMS, 0);

		write_thresholds(TEXT_PCT_RESET, CONFIG_PCT_RESET);
		run_random(PHASE_ITEMS, 0);

		drain_results();
		repeat (10) @(posedge clk);
		if (class_words_due.size() != 0) begin
			mismatches += class_words_due.size();
			$display("%0d class words never arrived", class_words_due.size());
		end
		if (mismatches == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
